// ===== rtl/lfo_generator_delay_fade_macros.svh =====
// Assertion macros shared by the LFO block.
`ifndef LFO_GENERATOR_DELAY_FADE_MACROS_SVH
`define LFO_GENERATOR_DELAY_FADE_MACROS_SVH

// Same-cycle implication, masked during reset.
`define LFOGDF_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define LFOGDF_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/lfogdf_pkg.sv =====
// Types, codes and constants of the LFO block.
`default_nettype none

package lfogdf_pkg;

    localparam int CMD_W      = 1;
    localparam int DT_W       = 24;
    localparam int VALUE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    localparam logic [22:0] RATE_MAX  = 23'd6553600;
    localparam logic [16:0] DEPTH_ONE = 17'd65536;
    localparam logic [15:0] MAG_ONE   = 16'd32768;

    // Sine polynomial coefficients, unsigned Q30
    localparam logic [31:0] SC1 = 32'd1686629713;
    localparam logic [31:0] SC3 = 32'd693598668;
    localparam logic [31:0] SC5 = 32'd85569306;
    localparam logic [31:0] SC7 = 32'd5026996;
    localparam logic [31:0] SC9 = 32'd172272;

    localparam logic [1:0] POLY_LAST = 2'd3;
    localparam logic [3:0] DIV_LAST  = 4'd15;

    typedef enum logic [0:0] {
        CMD_TICK    = 1'b0,
        CMD_NOTE_ON = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_RATE     = 3'd0,
        CFG_DELAY    = 3'd1,
        CFG_FADE     = 3'd2,
        CFG_WAVEFORM = 3'd3,
        CFG_BIPOLAR  = 3'd4,
        CFG_DEPTH    = 3'd5,
        CFG_KEY_SYNC = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        WAVE_SINE     = 3'd0,
        WAVE_TRIANGLE = 3'd1,
        WAVE_SQUARE   = 3'd2,
        WAVE_SAW      = 3'd3,
        WAVE_SAH      = 3'd4
    } wave_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ELAPSE,
        ST_NOW,
        ST_CHECK,
        ST_PHASE,
        ST_WAVE,
        ST_SQ,
        ST_POLY,
        ST_SFIN,
        ST_UNI,
        ST_DEPTH,
        ST_FLO,
        ST_FHI,
        ST_DIV,
        ST_FIN
    } state_t;

    // Wave shaper result: plain waves in w, sine as operand and sign
    typedef struct packed {
        logic signed [17:0] w;
        logic               sine;
        logic        [30:0] x;
        logic               neg;
    } wave_t;

    function automatic logic [31:0] sine_coef(input logic [1:0] step);
        logic [31:0] c;
        unique case (step)
            2'd0:    c = SC7;
            2'd1:    c = SC5;
            2'd2:    c = SC3;
            default: c = SC1;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lfogdf_if.sv =====
// Handshake channels of the LFO block: tick input, result output, register writes.
`default_nettype none

interface lfogdf_item_if import lfogdf_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CMD_W-1:0] command;
    logic [DT_W-1:0] delta_time;

    modport source (output valid, command, delta_time, input ready);
    modport sink   (input valid, command, delta_time, output ready);
endinterface

interface lfogdf_result_if import lfogdf_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] lfo_value;
    logic                      in_delay;

    modport source (output valid, lfo_value, in_delay, input ready);
    modport sink   (input valid, lfo_value, in_delay, output ready);
endinterface

interface lfogdf_cfg_if import lfogdf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lfogdf_mul.sv =====
// Shared 32x32 unsigned multiplier with registered product.
`default_nettype none

module lfogdf_mul import lfogdf_pkg::*; (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(a) * 64'(b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/lfogdf_wave.sv =====
// Wave shaper: triangle, square, saw and sample-and-hold, plus the sine operand.
`default_nettype none

module lfogdf_wave import lfogdf_pkg::*; #(
    parameter int SINE_TABLE_DEPTH    = 1024,
    parameter int PHASE_FRACTION_BITS = 32
) (
    input  logic [63:0] phase,
    input  logic [2:0]  waveform,
    output wave_t       wave
);

    localparam int          SINE_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam logic [31:0] SINE_MASK = ~((32'd1 << (32 - SINE_BITS)) - 32'd1);

    logic [31:0] frac;
    logic [31:0] p;
    logic [1:0]  quad;
    logic [30:0] r;
    logic [31:0] tri_d;
    logic [31:0] s0;
    logic [31:0] s1;
    logic [31:0] s2;
    logic [31:0] s3;

    always_comb
    begin
        frac = 32'(phase[PHASE_FRACTION_BITS-1:0]) << (32 - PHASE_FRACTION_BITS);

        // Snap to the table grid, then fold into the first quadrant
        p    = frac & SINE_MASK;
        quad = p[31:30];
        r    = {1'b0, p[29:0]};

        tri_d = frac[31] ? (frac - 32'h8000_0000) : (32'h8000_0000 - frac);

        s0 = phase[PHASE_FRACTION_BITS +: 32];
        s1 = s0 ^ (s0 << 13);
        s2 = s1 ^ (s1 >> 17);
        s3 = s2 ^ (s2 << 5);

        wave.sine = 1'b0;
        wave.x    = quad[0] ? (31'h4000_0000 - r) : r;
        wave.neg  = quad[1];

        unique case (wave_sel_t'(waveform))
            WAVE_SINE:
            begin
                wave.w    = 18'sd0;
                wave.sine = 1'b1;
            end
            WAVE_TRIANGLE: wave.w = 18'sd32768 - $signed({1'b0, 17'(tri_d >> 15)});
            WAVE_SQUARE:   wave.w = frac[31] ? -18'sd32768 : 18'sd32768;
            WAVE_SAW:      wave.w = $signed({2'b00, frac[31:16]}) - 18'sd32768;
            WAVE_SAH:      wave.w = $signed({2'b00, s3[31:16]}) - 18'sd32768;
            default:       wave.w = 18'sd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/lfo_generator_delay_fade.sv =====
// Top level of the modulation LFO with start delay, fade-in and sample-and-hold.
//
// Usage:
//   item   : tick words (command 0, delta_time in 2^-32 s) and note-on words
//            (command 1). Ready only while the sequencer is idle.
//   result : one word per tick (lfo_value Q1.15, in_delay flag); none per note on.
//   cfg    : register writes, index 0..6 as rate, delay, fade, waveform,
//            bipolar, depth, key sync; always ready, write only while idle.
// Timing: a note on is handled in the idle state. A tick in its delay goes
//   through ELAPSE, NOW and CHECK, then loads its result in FIN; a running
//   tick also goes through PHASE, WAVE, UNI and DEPTH, plus SQ, POLY and SFIN
//   for the sine polynomial and FLO, FHI and DIV for the fade-in scaling. The
//   next item waits for the return to idle. The steps follow the single shared
//   32x32 multiplier, which every product passes in turn, and the 16-step fade divider.
// Reset: registers take their default values, phase and elapsed time clear,
//   no result pending.
// Stall: a finished result sits in the output register; the next word is
//   taken meanwhile, and a later result waits in its last step until the
//   output register frees up.
`default_nettype none

`include "lfo_generator_delay_fade_macros.svh"

module lfo_generator_delay_fade import lfogdf_pkg::*; #(
    parameter int SINE_TABLE_DEPTH    = 1024,
    parameter int PHASE_FRACTION_BITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    lfogdf_item_if.sink     item,
    lfogdf_result_if.source result,
    lfogdf_cfg_if.sink      cfg
);

    localparam int INC_SHIFT = 48 - PHASE_FRACTION_BITS;

    // Sequencer
    state_t state_reg;
    state_t state_next;

    // Configuration registers
    logic [22:0] rate_reg;
    logic [15:0] delay_reg;
    logic [15:0] fade_reg;
    logic [2:0]  waveform_reg;
    logic        bipolar_reg;
    logic [16:0] depth_reg;
    logic        key_sync_reg;

    // Oscillator state
    logic [63:0] phase_reg;
    logic [47:0] elapsed_reg;

    // Per-tick working registers
    logic [23:0]        dt_reg;
    logic [57:0]        now_reg;
    logic [57:0]        a_reg;
    logic               in_delay_reg;
    logic               fade_on_reg;
    logic signed [17:0] w_reg;
    logic [30:0]        x_reg;
    logic [30:0]        x2_reg;
    logic               neg_reg;
    logic [1:0]         poly_cnt_reg;
    logic               sign_reg;
    logic [15:0]        mag_reg;
    logic [15:0]        lo_hi_reg;
    logic [15:0]        rem_reg;
    logic [15:0]        quo_reg;
    logic [3:0]         div_cnt_reg;

    // Output register
    logic        res_valid_reg;
    logic [15:0] res_value_reg;
    logic        res_delay_reg;

    // Combinational helpers
    logic               item_acc;
    logic               res_load;
    logic [48:0]        elapsed_sum;
    logic [57:0]        now_c;
    logic [47:0]        dend_c;
    logic               in_delay_c;
    logic               fade_on_c;
    logic [22:0]        rate_c;
    logic [16:0]        depth_c;
    logic [63:0]        inc_c;
    logic [30:0]        x2_c;
    logic [31:0]        t_c;
    logic [33:0]        s_round;
    logic [18:0]        q_raw;
    logic [15:0]        q_cap;
    logic signed [17:0] w_sum;
    logic signed [17:0] w_u;
    logic               sign_u;
    logic [15:0]        mag_u;
    logic [15:0]        mag_d;
    logic [31:0]        n_c;
    logic [16:0]        trial;
    logic               ge;
    logic [15:0]        mag_f;
    logic [15:0]        value_f;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_prod;
    wave_t       wave;

    lfogdf_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    lfogdf_wave #(
        .SINE_TABLE_DEPTH    (SINE_TABLE_DEPTH),
        .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
    ) u_wave (
        .phase    (phase_reg),
        .waveform (waveform_reg),
        .wave     (wave)
    );

    assign item_acc = item.valid && item.ready;
    assign res_load = (state_reg == ST_FIN) && (!res_valid_reg || result.ready);

    // Datapath arithmetic
    always_comb
    begin
        elapsed_sum = {1'b0, elapsed_reg} + 49'(dt_reg);
        // elapsed * 1000 as 1024 - 16 - 8
        now_c = {elapsed_reg, 10'b0} - 58'({elapsed_reg, 4'b0}) - 58'({elapsed_reg, 3'b0});
        dend_c     = {delay_reg, 32'b0};
        in_delay_c = now_reg < 58'(dend_c);
        // a < fade << 32 reduces to a compare on bits 47:32
        fade_on_c  = (fade_reg != 16'd0) && (a_reg[57:48] == 10'd0)
                     && (a_reg[47:32] < fade_reg);

        rate_c  = (rate_reg > RATE_MAX) ? RATE_MAX : rate_reg;
        depth_c = (depth_reg > DEPTH_ONE) ? DEPTH_ONE : depth_reg;
        inc_c   = mul_prod >> INC_SHIFT;

        // Horner steps of the sine polynomial
        x2_c    = 31'(mul_prod >> 30);
        t_c     = sine_coef(poly_cnt_reg) - 32'(mul_prod >> 30);
        s_round = 34'(mul_prod >> 30) + 34'd16384;
        q_raw   = 19'(s_round >> 15);
        q_cap   = (q_raw > 19'(MAG_ONE)) ? MAG_ONE : 16'(q_raw);

        // Unipolar map and split into sign and magnitude
        w_sum  = w_reg + 18'sd32768;
        w_u    = bipolar_reg ? w_reg : (w_sum >>> 1);
        sign_u = w_u < 18'sd0;
        mag_u  = sign_u ? 16'(-w_u) : 16'(w_u);

        mag_d = 16'(mul_prod >> 16);
        n_c   = mul_prod[31:0] + {16'b0, lo_hi_reg};

        trial = {rem_reg, quo_reg[15]};
        ge    = trial >= {1'b0, fade_reg};

        mag_f = fade_on_reg ? quo_reg : mag_reg;
        if (sign_reg)
        begin
            value_f = 16'(-{1'b0, mag_f});
        end
        else
        begin
            value_f = mag_f[15] ? 16'h7FFF : mag_f;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_acc && (item.command == CMD_TICK))
                begin
                    state_next = ST_ELAPSE;
                end
            end
            ST_ELAPSE: state_next = ST_NOW;
            ST_NOW:    state_next = ST_CHECK;
            ST_CHECK:  state_next = in_delay_c ? ST_FIN : ST_PHASE;
            ST_PHASE:  state_next = ST_WAVE;
            ST_WAVE:   state_next = wave.sine ? ST_SQ : ST_UNI;
            ST_SQ:     state_next = ST_POLY;
            ST_POLY:
            begin
                if (poly_cnt_reg == POLY_LAST)
                begin
                    state_next = ST_SFIN;
                end
            end
            ST_SFIN:   state_next = ST_UNI;
            ST_UNI:    state_next = ST_DEPTH;
            ST_DEPTH:  state_next = fade_on_reg ? ST_FLO : ST_FIN;
            ST_FLO:    state_next = ST_FHI;
            ST_FHI:    state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (res_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and multiplier operands
    always_comb
    begin
        item.ready = 1'b0;
        mul_a      = 32'd0;
        mul_b      = 32'd0;
        unique case (state_reg)
            ST_IDLE:  item.ready = 1'b1;
            ST_CHECK:
            begin
                mul_a = 32'(rate_c);
                mul_b = 32'(dt_reg);
            end
            ST_WAVE:
            begin
                mul_a = {1'b0, wave.x};
                mul_b = {1'b0, wave.x};
            end
            ST_SQ:
            begin
                mul_a = {1'b0, x2_c};
                mul_b = SC9;
            end
            ST_POLY:
            begin
                mul_a = (poly_cnt_reg == POLY_LAST) ? {1'b0, x_reg} : {1'b0, x2_reg};
                mul_b = t_c;
            end
            ST_UNI:
            begin
                mul_a = 32'(mag_u);
                mul_b = 32'(depth_c);
            end
            ST_DEPTH:
            begin
                mul_a = 32'(mag_d);
                mul_b = a_reg[31:0];
            end
            ST_FLO:
            begin
                mul_a = 32'(mag_reg);
                mul_b = 32'(a_reg[47:32]);
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign cfg.ready        = 1'b1;
    assign result.valid     = res_valid_reg;
    assign result.lfo_value = res_value_reg;
    assign result.in_delay  = res_delay_reg;

    // Control state, configuration and oscillator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rate_reg      <= 23'd327680;
            delay_reg     <= 16'd0;
            fade_reg      <= 16'd0;
            waveform_reg  <= WAVE_SINE;
            bipolar_reg   <= 1'b1;
            depth_reg     <= DEPTH_ONE;
            key_sync_reg  <= 1'b1;
            phase_reg     <= 64'd0;
            elapsed_reg   <= 48'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg_idx_t'(cfg.index))
                    CFG_RATE:     rate_reg     <= cfg.data[22:0];
                    CFG_DELAY:    delay_reg    <= cfg.data[15:0];
                    CFG_FADE:     fade_reg     <= cfg.data[15:0];
                    CFG_WAVEFORM: waveform_reg <= cfg.data[2:0];
                    CFG_BIPOLAR:  bipolar_reg  <= cfg.data[0];
                    CFG_DEPTH:    depth_reg    <= cfg.data[16:0];
                    CFG_KEY_SYNC: key_sync_reg <= cfg.data[0];
                    default:      ;
                endcase
            end

            // Note on: restart the timeline, and the phase under key sync
            if ((state_reg == ST_IDLE) && item_acc && (item.command == CMD_NOTE_ON))
            begin
                elapsed_reg <= 48'd0;
                if (key_sync_reg)
                begin
                    phase_reg <= 64'd0;
                end
            end

            // Saturate elapsed time at full scale
            if (state_reg == ST_ELAPSE)
            begin
                elapsed_reg <= elapsed_sum[48] ? {48{1'b1}} : elapsed_sum[47:0];
            end

            if (state_reg == ST_PHASE)
            begin
                phase_reg <= phase_reg + inc_c;
            end

            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            dt_reg <= item.delta_time;
        end

        unique case (state_reg)
            ST_NOW: now_reg <= now_c;
            ST_CHECK:
            begin
                a_reg        <= now_reg - 58'(dend_c);
                in_delay_reg <= in_delay_c;
                if (in_delay_c)
                begin
                    mag_reg     <= 16'd0;
                    sign_reg    <= 1'b0;
                    fade_on_reg <= 1'b0;
                end
            end
            ST_PHASE: fade_on_reg <= fade_on_c;
            ST_WAVE:
            begin
                w_reg        <= wave.w;
                x_reg        <= wave.x;
                neg_reg      <= wave.neg;
                poly_cnt_reg <= 2'd0;
            end
            ST_SQ:   x2_reg <= x2_c;
            ST_POLY: poly_cnt_reg <= poly_cnt_reg + 2'd1;
            ST_SFIN:
            begin
                w_reg <= neg_reg ? -$signed({2'b00, q_cap}) : $signed({2'b00, q_cap});
            end
            ST_UNI:   sign_reg  <= sign_u;
            ST_DEPTH: mag_reg   <= mag_d;
            ST_FLO:   lo_hi_reg <= mul_prod[47:32];
            ST_FHI:
            begin
                // Upper half starts as the partial remainder, lower half shifts in
                rem_reg     <= n_c[31:16];
                quo_reg     <= n_c[15:0];
                div_cnt_reg <= 4'd0;
            end
            ST_DIV:
            begin
                rem_reg     <= ge ? 16'(trial - {1'b0, fade_reg}) : trial[15:0];
                quo_reg     <= {quo_reg[14:0], ge};
                div_cnt_reg <= div_cnt_reg + 4'd1;
            end
            default: ;
        endcase

        if (res_load)
        begin
            res_value_reg <= value_f;
            res_delay_reg <= in_delay_reg;
        end
    end

    // Checks
    `LFOGDF_ASSERT_IMP(a_delay_zero, clk, rst_n, result.valid && result.in_delay, result.lfo_value == 16'sd0, "delayed word carries a non-zero value")
    `LFOGDF_ASSERT_NXT(a_note_clear, clk, rst_n, item_acc && (item.command == CMD_NOTE_ON), elapsed_reg == 48'd0, "note on did not clear elapsed time")
    `LFOGDF_ASSERT_IMP(a_div_rem, clk, rst_n, state_reg == ST_DIV, rem_reg < fade_reg, "fade divider remainder out of range")
    `LFOGDF_ASSERT_IMP(a_mag_range, clk, rst_n, state_reg == ST_FIN, mag_f <= MAG_ONE, "final magnitude above one")

endmodule

`default_nettype wire

// ===== dv/lfo_value_checker.sv =====
// Channel monitor for the LFO block: predicts every tick's result word and compares it.
`timescale 1ns / 1ps

module lfo_value_checker import lfogdf_pkg::*; #(
    parameter int SINE_TABLE_DEPTH    = 1024,
    parameter int PHASE_FRACTION_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    lfogdf_item_if      item,
    lfogdf_result_if    result,
    lfogdf_cfg_if       cfg,
    output int unsigned mismatch_count,
    output int unsigned words_outstanding
);

    typedef struct packed {
        logic signed [15:0] value;
        logic               in_delay;
    } lfo_word_t;

    localparam logic [22:0] RATE_RESET     = 23'd327680;
    localparam logic [16:0] DEPTH_RESET    = 17'd65536;
    localparam logic [47:0] ELAPSED_SAT    = 48'hFFFF_FFFF_FFFF;
    localparam int          ONE_Q15        = 32768;

    // Odd Taylor terms of sin(pi/2 x), unsigned Q30
    localparam logic [63:0] TAYLOR_C1 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_C3 = 64'd693598668;
    localparam logic [63:0] TAYLOR_C5 = 64'd85569306;
    localparam logic [63:0] TAYLOR_C7 = 64'd5026996;
    localparam logic [63:0] TAYLOR_C9 = 64'd172272;

    logic [22:0] rate_reg;
    logic [15:0] delay_reg;
    logic [15:0] fade_reg;
    logic [2:0]  wave_reg;
    logic        bipolar_reg;
    logic [16:0] depth_reg;
    logic        key_sync_reg;

    logic [63:0] phase;
    logic [47:0] elapsed;

    lfo_word_t expected_words[$];

    function automatic int sine_from_phase(input logic [31:0] frac);
        logic [63:0] step;
        logic [63:0] angle;
        logic [63:0] rem;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] acc;
        logic [63:0] s;
        logic [63:0] mag;
        logic [1:0]  quad;
        step  = ({32'd0, frac} * 64'(SINE_TABLE_DEPTH)) >> 32;
        angle = (step << 32) / 64'(SINE_TABLE_DEPTH);
        quad  = angle[31:30];
        rem   = {34'd0, angle[29:0]};
        x     = quad[0] ? (64'h4000_0000 - rem) : rem;
        x2    = (x * x) >> 30;
        acc   = TAYLOR_C7 - ((x2 * TAYLOR_C9) >> 30);
        acc   = TAYLOR_C5 - ((x2 * acc) >> 30);
        acc   = TAYLOR_C3 - ((x2 * acc) >> 30);
        acc   = TAYLOR_C1 - ((x2 * acc) >> 30);
        s     = (x * acc) >> 30;
        mag   = (s + 64'd16384) >> 15;
        if (mag > 64'd32768)
            mag = 64'd32768;
        return quad[1] ? -int'(mag) : int'(mag);
    endfunction

    // v * num / den, truncated towards zero
    function automatic int scale_toward_zero(input int v, input logic [63:0] num,
                                             input logic [63:0] den);
        logic [63:0] mag;
        mag = (v < 0) ? 64'(-v) : 64'(v);
        mag = (mag * num) / den;
        return (v < 0) ? -int'(mag) : int'(mag);
    endfunction

    // Advance elapsed time and phase by one tick and form its result word
    function automatic lfo_word_t predict_tick(input logic [23:0] dt);
        logic [63:0] sum;
        logic [63:0] now_t;
        logic [63:0] delay_end;
        logic [63:0] rate;
        logic [63:0] ramp;
        logic [63:0] fade_span;
        logic [63:0] depth;
        logic [31:0] frac;
        logic [31:0] offset;
        logic [31:0] hold;
        int          w;
        lfo_word_t   word;
        sum       = {16'd0, elapsed} + {40'd0, dt};
        elapsed   = (sum > {16'd0, ELAPSED_SAT}) ? ELAPSED_SAT : sum[47:0];
        now_t     = {16'd0, elapsed} * 64'd1000;
        delay_end = {16'd0, delay_reg, 32'd0};
        if (now_t < delay_end)
        begin
            word.value    = '0;
            word.in_delay = 1'b1;
            return word;
        end

        rate  = (rate_reg > RATE_MAX) ? 64'(RATE_MAX) : 64'(rate_reg);
        phase = phase + ((rate * {40'd0, dt}) >> (48 - PHASE_FRACTION_BITS));
        frac  = 32'((phase & ((64'd1 << PHASE_FRACTION_BITS) - 64'd1))
                    << (32 - PHASE_FRACTION_BITS));

        case (wave_reg)
            WAVE_SINE:
                w = sine_from_phase(frac);
            WAVE_TRIANGLE:
            begin
                offset = frac[31] ? (frac - 32'h8000_0000) : (32'h8000_0000 - frac);
                w = ONE_Q15 - int'(offset >> 15);
            end
            WAVE_SQUARE:
                w = frac[31] ? -ONE_Q15 : ONE_Q15;
            WAVE_SAW:
                w = int'(frac >> 16) - ONE_Q15;
            WAVE_SAH:
            begin
                hold = 32'(phase >> PHASE_FRACTION_BITS);
                hold = hold ^ (hold << 13);
                hold = hold ^ (hold >> 17);
                hold = hold ^ (hold << 5);
                w = int'(hold >> 16) - ONE_Q15;
            end
            default:
                w = 0;
        endcase

        if (!bipolar_reg)
            w = (w + ONE_Q15) >>> 1;

        depth = (depth_reg > DEPTH_ONE) ? 64'(DEPTH_ONE) : 64'(depth_reg);
        w = scale_toward_zero(w, depth, 64'(DEPTH_ONE));

        if (fade_reg != 16'd0)
        begin
            ramp      = now_t - delay_end;
            fade_span = {16'd0, fade_reg, 32'd0};
            if (ramp < fade_span)
                w = scale_toward_zero(w, ramp, fade_span);
        end

        if (w > 32767)
            w = 32767;
        else if (w < -32768)
            w = -32768;
        word.value    = 16'(w);
        word.in_delay = 1'b0;
        return word;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lfo_word_t   want;
        lfo_word_t   got;
        int unsigned fails;
        fails = 0;
        if (!rst_n)
        begin
            rate_reg     = RATE_RESET;
            delay_reg    = '0;
            fade_reg     = '0;
            wave_reg     = WAVE_SINE;
            bipolar_reg  = 1'b1;
            depth_reg    = DEPTH_RESET;
            key_sync_reg = 1'b1;
            phase        = '0;
            elapsed      = '0;
            expected_words.delete();
            mismatch_count    <= 0;
            words_outstanding <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_RATE:     rate_reg     = cfg.data[22:0];
                    CFG_DELAY:    delay_reg    = cfg.data[15:0];
                    CFG_FADE:     fade_reg     = cfg.data[15:0];
                    CFG_WAVEFORM: wave_reg     = cfg.data[2:0];
                    CFG_BIPOLAR:  bipolar_reg  = cfg.data[0];
                    CFG_DEPTH:    depth_reg    = cfg.data[16:0];
                    CFG_KEY_SYNC: key_sync_reg = cfg.data[0];
                    default:      ;
                endcase
            end

            // Check the outgoing word before queueing the incoming one
            if (result.valid && result.ready)
            begin
                got.value    = result.lfo_value;
                got.in_delay = result.in_delay;
                if (expected_words.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result word, expected none, actual lfo_value %0d in_delay %0b",
                             $time, got.value, got.in_delay);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got.value !== want.value)
                    begin
                        fails++;
                        $display("%0t: lfo_value mismatch, expected %0d, actual %0d",
                                 $time, want.value, got.value);
                    end
                    if (got.in_delay !== want.in_delay)
                    begin
                        fails++;
                        $display("%0t: in_delay mismatch, expected %0b, actual %0b",
                                 $time, want.in_delay, got.in_delay);
                    end
                end
            end

            if (item.valid && item.ready)
            begin
                if (item.command == CMD_NOTE_ON)
                begin
                    elapsed = '0;
                    if (key_sync_reg)
                        phase = '0;
                end
                else
                    expected_words.push_back(predict_tick(item.delta_time));
            end

            words_outstanding <= expected_words.size();
            mismatch_count    <= mismatch_count + fails;
        end
    end

endmodule

// ===== dv/tb_lfo_generator_delay_fade.sv =====
// Top of the LFO testbench: clock, reset, stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module tb_lfo_generator_delay_fade;
    import lfogdf_pkg::*;

    localparam int          SETTLE_CYCLES  = 48;     // beyond the slowest tick
    localparam int          RANDOM_WORDS   = 800;
    localparam int          MAX_IDLE       = 14;
    localparam logic [23:0] DT_MAX         = 24'hFF_FFFF;
    localparam logic [22:0] RATE_FIELD_MAX = 23'h7F_FFFF;
    localparam logic [16:0] DEPTH_FIELD_MAX = 17'h1_FFFF;
    localparam logic [15:0] MS_FIELD_MAX   = 16'hFFFF;
    localparam logic [2:0]  WAVE_UNDEFINED = 3'd7;

    typedef struct {
        logic [22:0] rate;
        logic [15:0] delay;
        logic [15:0] fade;
        logic [2:0]  wave;
        logic        bipolar;
        logic [16:0] depth;
        logic        key_sync;
    } lfo_settings_t;

    logic        clk;
    logic        rst_n;
    logic        quiet;          // when set, neither side idles
    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned random_words;

    lfogdf_item_if   item_ch ();
    lfogdf_result_if result_ch ();
    lfogdf_cfg_if    cfg_ch ();

    lfo_generator_delay_fade DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    lfo_value_checker value_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .item              (item_ch),
        .result            (result_ch),
        .cfg               (cfg_ch),
        .mismatch_count    (mismatches),
        .words_outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Hard stop should the block hang or lose a word
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Offer one word; idle first for a random gap, then hold it until it is taken.
    // Valid is left high so a back-to-back word does not need it lowered and raised again.
    task automatic send_word(input cmd_t cmd, input logic [23:0] dt);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.command    <= cmd;
        item_ch.delta_time <= dt;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    // Register write; valid stays up for a following write, end_writes drops it
    task automatic write_reg(input cfg_idx_t idx, input logic [22:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    task automatic end_writes();
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic apply_settings(input lfo_settings_t s);
        write_reg(CFG_RATE,     s.rate);
        write_reg(CFG_DELAY,    23'(s.delay));
        write_reg(CFG_FADE,     23'(s.fade));
        write_reg(CFG_WAVEFORM, 23'(s.wave));
        write_reg(CFG_BIPOLAR,  23'(s.bipolar));
        write_reg(CFG_DEPTH,    23'(s.depth));
        write_reg(CFG_KEY_SYNC, 23'(s.key_sync));
        end_writes();
    endtask

    // Hold the sender until every expected word is back, then let a trailing
    // note on finish before the registers may be touched again
    task automatic settle();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Time steps: mostly full range, with tiny and maximal steps mixed in
    function automatic logic [23:0] draw_step();
        case ($urandom_range(0, 9))
            0:       return 24'($urandom_range(0, 255));
            1:       return DT_MAX;
            2:       return 24'($urandom_range(0, 1 << 20));
            default: return 24'($urandom);
        endcase
    endfunction

    // Short delays and fades so that most phases cross both; the long ones
    // and out-of-range rate, depth and wave codes turn up now and then
    function automatic lfo_settings_t draw_settings();
        lfo_settings_t s;
        case ($urandom_range(0, 5))
            0:       s.rate = '0;
            1:       s.rate = RATE_MAX;
            2:       s.rate = 23'($urandom_range(int'(RATE_MAX) + 1, int'(RATE_FIELD_MAX)));
            default: s.rate = 23'($urandom_range(0, int'(RATE_MAX)));
        endcase
        case ($urandom_range(0, 9))
            5, 6, 7: s.delay = 16'($urandom_range(1, 30));
            8:       s.delay = 16'($urandom);
            9:       s.delay = MS_FIELD_MAX;
            default: s.delay = '0;
        endcase
        case ($urandom_range(0, 8))
            3, 4, 5, 6: s.fade = 16'($urandom_range(1, 40));
            7:          s.fade = 16'($urandom);
            8:          s.fade = MS_FIELD_MAX;
            default:    s.fade = '0;
        endcase
        if ($urandom_range(0, 7) == 0)
            s.wave = 3'($urandom_range(int'(WAVE_SAH) + 1, int'(WAVE_UNDEFINED)));
        else
            s.wave = 3'($urandom_range(int'(WAVE_SINE), int'(WAVE_SAH)));
        s.bipolar = 1'($urandom);
        case ($urandom_range(0, 5))
            0:       s.depth = '0;
            1, 2:    s.depth = DEPTH_ONE;
            3:       s.depth = 17'($urandom_range(int'(DEPTH_ONE) + 1, int'(DEPTH_FIELD_MAX)));
            default: s.depth = 17'($urandom_range(0, int'(DEPTH_ONE)));
        endcase
        s.key_sync = 1'($urandom);
        return s;
    endfunction

    // One phase: program, restart the note, then a run of mostly ticks with
    // the odd note on thrown in; drain before returning
    task automatic run_phase(input lfo_settings_t s, input int unsigned count);
        apply_settings(s);
        send_word(CMD_NOTE_ON, 24'($urandom));
        repeat (count)
        begin
            if ($urandom_range(0, 9) == 0)
                send_word(CMD_NOTE_ON, 24'($urandom));
            else
                send_word(CMD_TICK, draw_step());
            random_words++;
        end
        settle();
    endtask

    // Result side: stall a random number of cycles before each word
    initial
    begin
        int unsigned stall;
        result_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    initial
    begin
        wave_sel_t     wave;
        lfo_settings_t s;
        int unsigned   phase_no;

        rst_n              <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.command    <= CMD_TICK;
        item_ch.delta_time <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_RATE;
        cfg_ch.data        <= '0;
        quiet        = 1'b0;
        random_words = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: 5 Hz sine, full depth, no delay, no fade.
        // Zero and maximal steps; a note on must ignore its step.
        send_word(CMD_TICK, '0);
        send_word(CMD_TICK, DT_MAX);
        send_word(CMD_NOTE_ON, DT_MAX);
        send_word(CMD_TICK, DT_MAX);
        send_word(CMD_TICK, 24'h80_0000);
        send_word(CMD_TICK, 24'd1);
        settle();

        // One tick of every wave shape
        wave = wave.first();
        do
        begin
            write_reg(CFG_WAVEFORM, 23'(wave));
            end_writes();
            send_word(CMD_TICK, DT_MAX);
            settle();
            wave = wave.next();
        end
        while (wave != wave.first());

        // Start delay of 1 ms then a 2 ms fade: two ticks in delay,
        // then the ramp, then two long steps that carry past the fade
        s = '{rate: RATE_MAX, delay: 16'd1, fade: 16'd2, wave: WAVE_TRIANGLE,
              bipolar: 1'b1, depth: DEPTH_ONE, key_sync: 1'b1};
        apply_settings(s);
        send_word(CMD_NOTE_ON, '0);
        repeat (5) send_word(CMD_TICK, 24'h20_0000);
        repeat (2) send_word(CMD_TICK, DT_MAX);
        settle();

        // Undefined wave code, unipolar, rate and depth beyond their caps,
        // and a note on that must keep the phase without key sync
        s = '{rate: RATE_FIELD_MAX, delay: '0, fade: '0, wave: WAVE_UNDEFINED,
              bipolar: 1'b0, depth: DEPTH_FIELD_MAX, key_sync: 1'b0};
        apply_settings(s);
        send_word(CMD_TICK, DT_MAX);
        send_word(CMD_NOTE_ON, DT_MAX);
        send_word(CMD_TICK, DT_MAX);
        settle();

        // Register extremes: everything at zero, then everything at its top
        s = '{rate: '0, delay: '0, fade: '0, wave: WAVE_SINE,
              bipolar: 1'b0, depth: '0, key_sync: 1'b0};
        run_phase(s, 20);
        s = '{rate: RATE_FIELD_MAX, delay: MS_FIELD_MAX, fade: MS_FIELD_MAX,
              wave: WAVE_UNDEFINED, bipolar: 1'b1, depth: DEPTH_FIELD_MAX, key_sync: 1'b1};
        run_phase(s, 20);

        // Random phases; every fourth one runs with no idling on either side
        phase_no = 0;
        while (random_words < RANDOM_WORDS)
        begin
            quiet = (phase_no % 4 == 2);
            run_phase(draw_settings(), $urandom_range(20, 50));
            phase_no++;
        end
        quiet = 1'b0;

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
